// ===== design/sms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sms_pkg
// Types and constants shared by the stable merge sort block.
// ----------------------------------------------------------------------------
package sms_pkg;

  localparam int WORD_W = 32;

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic                     last_in;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] sorted_value;
    logic                     last_out;
    logic                     truncated;
  } out_word_t;

  typedef enum logic [1:0] {
    S_LOAD,
    S_START,
    S_MERGE,
    S_OUTPUT
  } state_t;

endpackage

// ===== design/sms_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sms_ram
// One write port, two read ports, registered read data with enables.
// ----------------------------------------------------------------------------
module sms_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [AW-1:0]                    wa,
  input  logic signed [sms_pkg::WORD_W-1:0] wd,
  input  logic                             rea,
  input  logic [AW-1:0]                    raa,
  output logic signed [sms_pkg::WORD_W-1:0] qa,
  input  logic                             reb,
  input  logic [AW-1:0]                    rab,
  output logic signed [sms_pkg::WORD_W-1:0] qb
);

  logic signed [sms_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rea) begin
      qa <= mem[raa];
    end
    if (reb) begin
      qb <= mem[rab];
    end
  end

endmodule

// ===== design/stable_merge_sort.sv =====
`timescale 1ns / 1ps
// Load: one word per cycle while idle; the word marked last starts the sort.
// Sort: one merge step per cycle for n stored words, bounded by the two
//   read ports of the ping-pong word memories.
// Output: one word per cycle while result_stall is low; read data is
//   registered in the memory and again in the output word register.
// Reset clears control state only; memory contents stay undefined.
// ----------------------------------------------------------------------------
// stable_merge_sort
// Buffers a list of signed words, sorts it with a stable bottom-up merge
// between two memories and streams the sorted list out.
// ----------------------------------------------------------------------------
module stable_merge_sort #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  sms_pkg::in_word_t    item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output sms_pkg::out_word_t   result
);

  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int AW = $clog2(MAX_ITEMS);
  localparam logic [CW-1:0] CAP = CW'(MAX_ITEMS);

  function automatic logic [CW-1:0] clamp_n(input logic [CW+1:0] v,
                                            input logic [CW-1:0] lim);
    logic [CW-1:0] r;
    if (v > {2'b00, lim}) r = lim;
    else r = v[CW-1:0];
    return r;
  endfunction

  sms_pkg::state_t state, state_next;

  logic [CW-1:0] count, count_next;
  logic          ovf, ovf_next;
  logic [CW-1:0] n, n_next;
  logic          sel, sel_next;
  logic [CW-1:0] w, w_next;
  logic [CW-1:0] i, i_next, mid, mid_next, j, j_next, hi, hi_next, k, k_next;
  logic [CW-1:0] o_idx, o_idx_next;
  logic          q_valid, q_valid_next, q_last, q_last_next;
  logic          fwd_a, fwd_a_next, fwd_b, fwd_b_next;
  logic signed [sms_pkg::WORD_W-1:0] fwd_word;
  logic          out_valid, out_valid_next;
  sms_pkg::out_word_t out_word;

  logic          we0, we1, rd_en_a, rd_en_b, fetch, load_out;
  logic [AW-1:0] wa, ra_a, ra_b;
  logic signed [sms_pkg::WORD_W-1:0] wd, merge_wd;
  logic signed [sms_pkg::WORD_W-1:0] qa0, qb0, qa1, qb1, data_a, data_b, mem_a;
  logic          take_i, accept;
  logic [CW:0]   w2;
  logic [CW-1:0] k1;

  sms_ram #(.DEPTH(MAX_ITEMS), .AW(AW)) u_ram0 (
    .clk(clk), .we(we0), .wa(wa), .wd(wd),
    .rea(rd_en_a), .raa(ra_a), .qa(qa0),
    .reb(rd_en_b), .rab(ra_b), .qb(qb0)
  );

  sms_ram #(.DEPTH(MAX_ITEMS), .AW(AW)) u_ram1 (
    .clk(clk), .we(we1), .wa(wa), .wd(wd),
    .rea(rd_en_a), .raa(ra_a), .qa(qa1),
    .reb(rd_en_b), .rab(ra_b), .qb(qb1)
  );

  assign mem_a    = sel ? qa1 : qa0;
  assign data_a   = fwd_a ? fwd_word : mem_a;
  assign data_b   = fwd_b ? fwd_word : (sel ? qb1 : qb0);
  assign take_i   = (i < mid) && (!(j < hi) || (data_a <= data_b));
  assign merge_wd = take_i ? data_a : data_b;
  assign item_stall = (state != sms_pkg::S_LOAD);
  assign accept   = item_valid && !item_stall;
  assign load_out = q_valid && (!out_valid || !result_stall);
  assign k1       = k + CW'(1);
  assign w2       = {w, 1'b0};

  always_comb begin
    state_next     = state;
    count_next     = count;
    ovf_next       = ovf;
    n_next         = n;
    sel_next       = sel;
    w_next         = w;
    i_next         = i;
    mid_next       = mid;
    j_next         = j;
    hi_next        = hi;
    k_next         = k;
    o_idx_next     = o_idx;
    fwd_a_next     = 1'b0;
    fwd_b_next     = 1'b0;
    we0            = 1'b0;
    we1            = 1'b0;
    wa             = k[AW-1:0];
    wd             = merge_wd;
    fetch          = 1'b0;

    case (state)
      sms_pkg::S_LOAD: begin
        wd = item.value;
        wa = count[AW-1:0];
        if (accept) begin
          if (count < CAP) begin
            we0        = 1'b1;
            count_next = count + CW'(1);
          end else begin
            ovf_next = 1'b1;
          end
          if (item.last_in) begin
            n_next     = count_next;
            state_next = sms_pkg::S_START;
          end
        end
      end
      sms_pkg::S_START: begin
        sel_next   = 1'b0;
        w_next     = CW'(1);
        i_next     = '0;
        mid_next   = CW'(1);
        j_next     = CW'(1);
        hi_next    = CW'(2);
        k_next     = '0;
        o_idx_next = '0;
        if (n == CW'(1)) state_next = sms_pkg::S_OUTPUT;
        else state_next = sms_pkg::S_MERGE;
      end
      sms_pkg::S_MERGE: begin
        we0    = sel;
        we1    = !sel;
        k_next = k1;
        if (take_i) i_next = i + CW'(1);
        else j_next = j + CW'(1);
        if (k1 == hi) begin
          if (hi == n) begin
            sel_next = !sel;
            if (w2 >= {1'b0, n}) begin
              o_idx_next = '0;
              state_next = sms_pkg::S_OUTPUT;
            end else begin
              // new pass reads the memory being written now
              w_next     = w2[CW-1:0];
              i_next     = '0;
              mid_next   = w2[CW-1:0];
              j_next     = w2[CW-1:0];
              hi_next    = clamp_n({w, 2'b00}, n);
              k_next     = '0;
              fwd_a_next = (k == CW'(0));
              fwd_b_next = (k == w2[CW-1:0]);
            end
          end else begin
            i_next   = hi;
            mid_next = clamp_n({2'b00, hi} + {2'b00, w}, n);
            j_next   = mid_next;
            hi_next  = clamp_n({2'b00, hi} + {1'b0, w, 1'b0}, n);
          end
        end
      end
      sms_pkg::S_OUTPUT: begin
        fetch = (o_idx < n) && (!q_valid || load_out);
        if (fetch) o_idx_next = o_idx + CW'(1);
        if ((o_idx == n) && !q_valid) begin
          count_next = '0;
          ovf_next   = 1'b0;
          state_next = sms_pkg::S_LOAD;
        end
      end
      default: begin
        state_next = sms_pkg::S_LOAD;
      end
    endcase

    rd_en_a = (state == sms_pkg::S_START) || (state == sms_pkg::S_MERGE) || fetch;
    rd_en_b = (state == sms_pkg::S_START) || (state == sms_pkg::S_MERGE);
    ra_a    = (state == sms_pkg::S_OUTPUT) ? o_idx[AW-1:0] : i_next[AW-1:0];
    ra_b    = j_next[AW-1:0];

    q_valid_next = fetch ? 1'b1 : (load_out ? 1'b0 : q_valid);
    q_last_next  = fetch ? (o_idx + CW'(1) == n) : q_last;
    out_valid_next = load_out ? 1'b1 : (result_stall ? out_valid : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sms_pkg::S_LOAD;
      count     <= '0;
      ovf       <= 1'b0;
      n         <= '0;
      sel       <= 1'b0;
      w         <= '0;
      i         <= '0;
      mid       <= '0;
      j         <= '0;
      hi        <= '0;
      k         <= '0;
      o_idx     <= '0;
      q_valid   <= 1'b0;
      q_last    <= 1'b0;
      fwd_a     <= 1'b0;
      fwd_b     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      ovf       <= ovf_next;
      n         <= n_next;
      sel       <= sel_next;
      w         <= w_next;
      i         <= i_next;
      mid       <= mid_next;
      j         <= j_next;
      hi        <= hi_next;
      k         <= k_next;
      o_idx     <= o_idx_next;
      q_valid   <= q_valid_next;
      q_last    <= q_last_next;
      fwd_a     <= fwd_a_next;
      fwd_b     <= fwd_b_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    fwd_word <= merge_wd;
    if (load_out) begin
      out_word.sorted_value <= mem_a;
      out_word.last_out     <= q_last;
      out_word.truncated    <= ovf;
    end
  end

  assign result_valid = out_valid;
  assign result       = out_word;

endmodule
